// ===== design/three_level_priority_queue_top_assert.svh =====
// assertion macros for the three level priority queue
`ifndef THREE_LEVEL_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define THREE_LEVEL_PRIORITY_QUEUE_TOP_ASSERT_SVH

// property checked on every clock edge outside reset
`define TPQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in any cycle implies consequent in the next
`define TPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tpq_pkg.sv =====
package tpq_pkg;

    localparam int NUM_LEVELS  = 3;
    localparam int LEVEL_DEPTH = 64;
    localparam int ID_BITS     = 16;

    // width of the identifier ports
    localparam int ID_PORT_W  = 16;
    localparam int STORE_BITS = (ID_BITS < ID_PORT_W) ? ID_BITS : ID_PORT_W;

    localparam int PTR_W = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
    // count reaches LEVEL_DEPTH, head plus count stays below twice the depth
    localparam int CNT_W = PTR_W + 1;

    localparam logic       OP_ENQ = 1'b0;
    localparam logic       OP_DEQ = 1'b1;
    localparam logic [1:0] LVL_BAD = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_LEVEL = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic full;
        logic grant;
    } tpq_cell_st_t;

endpackage

// ===== design/tpq_cell.sv =====
module tpq_cell
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           enq,
    input  logic                           deq_in,
    input  logic [tpq_pkg::STORE_BITS-1:0] id,
    output logic                           deq_out,
    output tpq_pkg::tpq_cell_st_t          st,
    output logic [tpq_pkg::STORE_BITS-1:0] rd_data
);
    import tpq_pkg::*;

    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(LEVEL_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(LEVEL_DEPTH - 1);

    logic [STORE_BITS-1:0] slot_mem [LEVEL_DEPTH];
    logic [STORE_BITS-1:0] rd_data_reg;
    logic [PTR_W-1:0]      head_reg;
    logic [PTR_W-1:0]      head_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [CNT_W-1:0]      tail_sum;
    logic [CNT_W-1:0]      tail_wrap;
    logic [PTR_W-1:0]      tail_idx;
    logic                  nonempty;
    logic                  full;
    logic                  grant;
    logic                  enq_ok;

    always_comb
    begin
        nonempty  = (count_reg != '0);
        full      = (count_reg == DEPTH_C);
        grant     = deq_in && nonempty;
        enq_ok    = enq && !full;
        tail_sum  = {1'b0, head_reg} + count_reg;
        tail_wrap = (tail_sum >= DEPTH_C) ? (tail_sum - DEPTH_C) : tail_sum;
        tail_idx  = tail_wrap[PTR_W-1:0];

        head_next  = head_reg;
        count_next = count_reg;
        if (enq_ok)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (grant)
        begin
            head_next  = (head_reg == LAST_PTR) ? '0 : head_reg + PTR_W'(1);
            count_next = count_reg - CNT_W'(1);
        end
    end

    // an empty level passes the dequeue token on to the next lower level
    assign deq_out  = deq_in && !nonempty;
    assign st.full  = full;
    assign st.grant = grant;
    assign rd_data  = rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq_ok)
        begin
            slot_mem[tail_idx] <= id;
        end
        if (grant)
        begin
            rd_data_reg <= slot_mem[head_reg];
        end
    end

endmodule

// ===== design/three_level_priority_queue_top.sv =====
// three level priority queue, first in first out within each level
//
// a command word (operation, item_id, level) is taken at a rising edge with
// start high and busy low. busy stays low: one word can be taken every cycle.
// each command word yields one result word (status, served_id, served_level),
// shown for exactly one cycle with done high, in the cycle right after the
// command was taken (throughput 1 word per cycle).
// the levels form a row of three cells, high level first; a dequeue token
// enters the high cell and moves down until a non-empty cell takes it.
// each cell keeps its own ring of LEVEL_DEPTH slots in a memory with one
// write and one registered read port, so a slot is read the cycle after the
// command and its data reaches served_id through a small level mux.
// an enqueue into a full level or with level 3 is dropped and flagged.
// reset clears the heads, the counts and done; ring contents are left as they
// are and are only read after being written. the receiver cannot hold off
// results, so nothing here ever waits on the output side.
module three_level_priority_queue_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          operation,
    input  logic [tpq_pkg::ID_PORT_W-1:0] item_id,
    input  logic [1:0]                    level,
    output logic                          done,
    output logic [1:0]                    status,
    output logic [tpq_pkg::ID_PORT_W-1:0] served_id,
    output logic [1:0]                    served_level
);
    import tpq_pkg::*;

    logic                  accept;
    logic                  deq_req;
    logic [NUM_LEVELS:0]   deq_tok;
    logic [NUM_LEVELS-1:0] enq_sel;
    logic [NUM_LEVELS-1:0] full_vec;
    logic [NUM_LEVELS-1:0] grant_vec;
    logic [STORE_BITS-1:0] store_id;
    logic [STORE_BITS-1:0] rd_data [NUM_LEVELS];
    tpq_cell_st_t          cell_st [NUM_LEVELS];

    logic                  done_reg;
    logic [1:0]            status_reg;
    logic [1:0]            status_next;
    logic [1:0]            served_level_reg;
    logic [1:0]            served_level_next;
    logic [NUM_LEVELS-1:0] grant_reg;
    logic [STORE_BITS-1:0] id_mux;

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign deq_req  = accept && (operation == OP_DEQ);
    assign store_id = item_id[STORE_BITS-1:0];
    assign deq_tok[NUM_LEVELS] = deq_req;

    genvar gl;
    generate
        for (gl = 0; gl < NUM_LEVELS; gl++)
        begin : g_cell
            assign enq_sel[gl] = accept && (operation == OP_ENQ) && (level == 2'(gl));

            tpq_cell u_cell
            (
                .clk     (clk),
                .rst_n   (rst_n),
                .enq     (enq_sel[gl]),
                .deq_in  (deq_tok[gl+1]),
                .id      (store_id),
                .deq_out (deq_tok[gl]),
                .st      (cell_st[gl]),
                .rd_data (rd_data[gl])
            );

            assign full_vec[gl]  = cell_st[gl].full;
            assign grant_vec[gl] = cell_st[gl].grant;
        end
    endgenerate

    always_comb
    begin
        served_level_next = 2'd0;
        for (int l = 0; l < NUM_LEVELS; l++)
        begin
            if (grant_vec[l])
            begin
                served_level_next = 2'(l);
            end
        end

        if (operation == OP_ENQ)
        begin
            if (level == LVL_BAD)
            begin
                status_next = ST_BAD_LEVEL;
            end
            else if ((enq_sel & full_vec) != '0)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                status_next = ST_OK;
            end
        end
        else
        begin
            // token fell out of the low cell: every level was empty
            status_next = deq_tok[0] ? ST_EMPTY : ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= 1'b0;
            grant_reg <= '0;
        end
        else
        begin
            done_reg  <= accept;
            grant_reg <= grant_vec;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg       <= status_next;
        served_level_reg <= served_level_next;
    end

    // grant_reg is one-hot or zero, so an unserved word reads as zero
    always_comb
    begin
        id_mux = '0;
        for (int l = 0; l < NUM_LEVELS; l++)
        begin
            if (grant_reg[l])
            begin
                id_mux = id_mux | rd_data[l];
            end
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign served_level = served_level_reg;
    assign served_id    = ID_PORT_W'(id_mux);

`include "three_level_priority_queue_top_assert.svh"

    `TPQ_ASSERT_NEXT(a_word_answered, accept, done, "accepted word gave no result")
    `TPQ_ASSERT(a_no_spurious, !done || $past(accept), "result without a command word")
    `TPQ_ASSERT(a_one_grant, $onehot0(grant_vec), "more than one level served a dequeue")
    `TPQ_ASSERT(a_zero_unserved, !done || (status == ST_OK) || ((served_id == '0) && (served_level == 2'd0)), "failed command reported an entry")

endmodule

// ===== tb/tpq_checker.sv =====
`timescale 1ns / 100ps

module tpq_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          operation,
    input  logic [tpq_pkg::ID_PORT_W-1:0] item_id,
    input  logic [1:0]                    level,
    input  logic                          done,
    input  logic [1:0]                    status,
    input  logic [tpq_pkg::ID_PORT_W-1:0] served_id,
    input  logic [1:0]                    served_level,
    output int                            error_count,
    output int                            pending
);
    import tpq_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [1:0]           status;
        logic [ID_PORT_W-1:0] id;
        logic [1:0]           lvl;
    } queue_result_t;

    // own copy of the three rings
    logic [STORE_BITS-1:0] ring_slots [NUM_LEVELS][LEVEL_DEPTH];
    int                    ring_head  [NUM_LEVELS];
    int                    ring_fill  [NUM_LEVELS];

    queue_result_t expected_results [$];
    queue_result_t oldest;

    function automatic queue_result_t serve_command(input logic op,
                                                    input logic [ID_PORT_W-1:0] id,
                                                    input logic [1:0] lvl);
        queue_result_t r;
        int            pick;
        int            tail;
        r.status = ST_OK;
        r.id     = '0;
        r.lvl    = 2'd0;
        if (op == OP_ENQ)
        begin
            if (lvl == LVL_BAD)
                r.status = ST_BAD_LEVEL;
            else if (ring_fill[lvl] >= LEVEL_DEPTH)
                r.status = ST_FULL;
            else
            begin
                tail = (ring_head[lvl] + ring_fill[lvl]) % LEVEL_DEPTH;
                ring_slots[lvl][tail] = id[STORE_BITS-1:0];
                ring_fill[lvl]++;
            end
        end
        else
        begin
            // highest level holding anything wins
            pick = -1;
            for (int k = NUM_LEVELS - 1; k >= 0; k--)
            begin
                if (pick < 0 && ring_fill[k] != 0)
                    pick = k;
            end
            if (pick < 0)
                r.status = ST_EMPTY;
            else
            begin
                r.id[STORE_BITS-1:0] = ring_slots[pick][ring_head[pick]];
                r.lvl                = pick[1:0];
                ring_head[pick]      = (ring_head[pick] + 1) % LEVEL_DEPTH;
                ring_fill[pick]--;
            end
        end
        return r;
    endfunction

    task automatic note_failure(input string what, input queue_result_t want);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t: %s: expected status %0d id %h level %0d, %s %0d id %h level %0d",
                     $realtime, what, want.status, want.id, want.lvl, "got status",
                     status, served_id, served_level);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_LEVELS; k++)
            begin
                ring_head[k] = 0;
                ring_fill[k] = 0;
            end
            expected_results.delete();
            error_count = 0;
            pending <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                    note_failure("result word with nothing outstanding", '0);
                else
                begin
                    oldest = expected_results.pop_front();
                    if (status !== oldest.status || served_id !== oldest.id ||
                        served_level !== oldest.lvl)
                        note_failure("result word mismatch", oldest);
                end
            end
            if (start && !busy)
                expected_results.push_back(serve_command(operation, item_id, level));
            pending <= expected_results.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import tpq_pkg::*;

    localparam int  RANDOM_WORDS = 700;
    localparam int  CYCLE_LIMIT  = 60000;
    localparam real HALF_PERIOD  = 10.0;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 operation;
    logic [ID_PORT_W-1:0] item_id;
    logic [1:0]           level;
    logic                 done;
    logic [1:0]           status;
    logic [ID_PORT_W-1:0] served_id;
    logic [1:0]           served_level;
    int                   error_count;
    int                   pending;
    int                   cycle_count;

    three_level_priority_queue_top u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .item_id      (item_id),
        .level        (level),
        .done         (done),
        .status       (status),
        .served_id    (served_id),
        .served_level (served_level)
    );

    tpq_checker u_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .item_id      (item_id),
        .level        (level),
        .done         (done),
        .status       (status),
        .served_id    (served_id),
        .served_level (served_level),
        .error_count  (error_count),
        .pending      (pending)
    );

    initial
        clk = 1'b0;

    always #(HALF_PERIOD) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // holds start high until the word is taken
    task automatic send_word(input logic op, input logic [ID_PORT_W-1:0] id,
                             input logic [1:0] lvl);
        start     <= 1'b1;
        operation <= op;
        item_id   <= id;
        level     <= lvl;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // stop sending and wait until every result word is back
    task automatic drain_results();
        idle_cycles(1);
        while (pending != 0)
            @(posedge clk);
    endtask

    int         sent;
    int         phase;
    int         phase_len;
    int         enq_pct;
    logic [1:0] flood_level;
    logic [1:0] lvl_pick;

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        operation = OP_ENQ;
        item_id   = '0;
        level     = 2'd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty queue, field extremes, bad level, priority order
        send_word(OP_DEQ, 16'hFFFF, 2'd3);
        send_word(OP_ENQ, 16'h0000, 2'd0);
        send_word(OP_ENQ, 16'hFFFF, 2'd1);
        send_word(OP_ENQ, 16'h5555, 2'd2);
        send_word(OP_ENQ, 16'hAAAA, LVL_BAD);
        send_word(OP_ENQ, 16'h1234, 2'd0);
        send_word(OP_ENQ, 16'h8001, 2'd2);
        idle_cycles(2);
        repeat (5) send_word(OP_DEQ, 16'h0000, 2'd0);
        send_word(OP_DEQ, 16'hAAAA, 2'd2);
        send_word(OP_ENQ, 16'h7FFF, LVL_BAD);
        send_word(OP_ENQ, 16'h0001, 2'd1);
        send_word(OP_ENQ, 16'hFFFE, 2'd0);
        send_word(OP_DEQ, 16'h5A5A, 2'd1);
        send_word(OP_DEQ, 16'hA5A5, 2'd3);
        send_word(OP_DEQ, 16'hFFFF, 2'd0);
        drain_results();

        // random: flood phases push levels to full, drain phases wrap the rings
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_WORDS)
        begin
            phase_len   = $urandom_range(120, 40);
            flood_level = 2'($urandom_range(2));
            case (phase % 3)
                0: enq_pct = 90;
                1: enq_pct = 20;
                default: enq_pct = 55;
            endcase
            for (int i = 0; i < phase_len && sent < RANDOM_WORDS; i++)
            begin
                if ($urandom_range(99) < enq_pct)
                begin
                    if (phase % 3 == 0 && $urandom_range(99) < 70)
                        lvl_pick = flood_level;
                    else if ($urandom_range(99) < 8)
                        lvl_pick = LVL_BAD;
                    else
                        lvl_pick = 2'($urandom_range(2));
                    send_word(OP_ENQ, ID_PORT_W'($urandom), lvl_pick);
                end
                else
                    send_word(OP_DEQ, ID_PORT_W'($urandom), 2'($urandom_range(3)));
                sent++;
                // quiet stretch in the middle keeps full rate for a while
                if ((sent < 250 || sent > 400) && $urandom_range(99) < 15)
                    idle_cycles($urandom_range(4, 1));
            end
            if (phase % 3 == 1)
                drain_results();
            phase++;
        end

        drain_results();
        repeat (4) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
